// ===== sv/tpc_pkg.sv =====
// Shared types and constants for the time period coalescer.
package tpc_pkg;

    localparam int unsigned TIME_W   = 48;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned GAP_W    = 32;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TOLERANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNORDERED     = 3'd5;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [LIMIT_W-1:0] COUNT_MAX = {LIMIT_W{1'b1}};

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  window_end;
        logic [GAP_W-1:0]   gap_tolerance;
        logic [LIMIT_W-1:0] period_limit;
        logic               descending;
        logic               unordered;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  open_start;
        logic [TIME_W-1:0]  open_length;
        logic               open_valid;
        logic [LIMIT_W-1:0] period_count;
        logic               stopped;
    } t_state;

    typedef struct packed {
        logic               req_type;
        logic [TIME_W-1:0]  start_ms;
        logic [DUR_W-1:0]   duration_ms;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0]  period_start;
        logic [TIME_W-1:0]  period_length;
        logic               from_flush;
        logic               limit_hit;
    } t_result;

endpackage

// ===== sv/time_period_coalescer.sv =====
// Top level of the time period coalescer: input stage, open period state, result stage.
//
// Input words arrive on the s_axis channel: tdata carries start_ms and
// duration_ms, tuser carries req_type (0 record, 1 flush). Each word is
// registered, then merged combinationally against the single open period, and
// a finished period, when there is one, lands in the result register that
// drives the m_axis channel (tdata: period_start, period_length; tuser:
// from_flush, limit_hit).
// Each word is registered in the input stage and its result in the result
// register. Throughput is one word per cycle unless the receiver stalls
// while both stages are full.
// A record that merges, is out of window or arrives while stopped, and a
// flush with no open period, give no result.
// When the receiver stalls, the result register holds and the input stage
// holds its word; s_axis_tready drops only while both are full.
// Synchronous active-low reset clears the stages, the open period and the
// configuration registers to their defaults. Write configuration through the
// i_cfg_* port only while the block is idle.
module time_period_coalescer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpc_pkg::TIME_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // start_ms[47:0], duration_ms[63:48]
    input  logic                          s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [95:0]                   m_axis_tdata,  // period_start[47:0], period_length[95:48]
    output logic [1:0]                    m_axis_tuser   // from_flush[0], limit_hit[1]
);

    tpc_pkg::t_cfg    cfg;
    tpc_pkg::t_state  r_state;
    tpc_pkg::t_state  n_state;
    tpc_pkg::t_item   r_item;
    tpc_pkg::t_result r_result;
    tpc_pkg::t_result core_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             core_emit;
    logic             advance;

    tpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tpc_merge_core u_core (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.req_type    <= s_axis_tuser;
            r_item.start_ms    <= s_axis_tdata[47:0];
            r_item.duration_ms <= s_axis_tdata[63:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_emit) begin
            r_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.period_length, r_result.period_start};
    assign m_axis_tuser  = {r_result.limit_hit, r_result.from_flush};

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled while a stage is free");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result marked both flush and limit");

    a_limit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_emit && core_result.limit_hit)
        |=> (r_state.stopped && !r_state.open_valid))
        else $error("limit result did not stop processing");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_item.req_type == tpc_pkg::REQ_FLUSH))
        |=> (r_state.period_count == '0 && !r_state.stopped && !r_state.open_valid))
        else $error("flush did not clear the run");

endmodule

// ===== sv/tpc_cfg_regs.sv =====
// Configuration register file of the time period coalescer.
module tpc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpc_pkg::TIME_W-1:0]     i_cfg_wdata,
    output tpc_pkg::t_cfg                  o_cfg
);

    tpc_pkg::t_cfg r_cfg;
    tpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tpc_pkg::REG_WINDOW_START:  n_cfg.window_start  = i_cfg_wdata;
                tpc_pkg::REG_WINDOW_END:    n_cfg.window_end    = i_cfg_wdata;
                tpc_pkg::REG_GAP_TOLERANCE:
                    n_cfg.gap_tolerance = i_cfg_wdata[tpc_pkg::GAP_W-1:0];
                tpc_pkg::REG_PERIOD_LIMIT:
                    n_cfg.period_limit  = i_cfg_wdata[tpc_pkg::LIMIT_W-1:0];
                tpc_pkg::REG_DESCENDING:    n_cfg.descending    = i_cfg_wdata[0];
                tpc_pkg::REG_UNORDERED:     n_cfg.unordered     = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start  <= '0;
            r_cfg.window_end    <= tpc_pkg::TIME_MAX;
            r_cfg.gap_tolerance <= '0;
            r_cfg.period_limit  <= '0;
            r_cfg.descending    <= 1'b0;
            r_cfg.unordered     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/tpc_merge_core.sv =====
// Combinational merge decision and next open period for one word.
module tpc_merge_core (
    input  tpc_pkg::t_cfg     i_cfg,
    input  tpc_pkg::t_state   i_state,
    input  tpc_pkg::t_item    i_item,
    output tpc_pkg::t_state   o_state,
    output logic              o_emit,
    output tpc_pkg::t_result  o_result
);

    localparam int unsigned W1 = tpc_pkg::TIME_W + 1;
    localparam int unsigned W2 = tpc_pkg::TIME_W + 2;

    logic [W1-1:0] rec_end;
    logic [W1-1:0] open_end;
    logic [W2-1:0] rec_end_gap;
    logic [W2-1:0] open_end_gap;
    logic [tpc_pkg::TIME_W-1:0] new_start;
    logic [W1-1:0] desc_len;
    logic [W1-1:0] asc_len;
    logic          in_window;
    logic          merge;
    logic          limit_reached;
    logic [tpc_pkg::LIMIT_W-1:0] count_inc;

    always_comb begin
        rec_end      = {1'b0, i_item.start_ms} + W1'(i_item.duration_ms);
        open_end     = {1'b0, i_state.open_start} + {1'b0, i_state.open_length};
        rec_end_gap  = {1'b0, rec_end} + W2'(i_cfg.gap_tolerance);
        open_end_gap = {1'b0, open_end} + W2'(i_cfg.gap_tolerance);
        in_window    = (i_item.start_ms <= i_cfg.window_end)
                    && (rec_end >= {1'b0, i_cfg.window_start});

        if (i_cfg.descending) begin
            merge = rec_end_gap >= W2'(i_state.open_start);
            if (i_cfg.unordered && (i_item.start_ms > i_state.open_start)) begin
                merge = 1'b0;
            end
        end else begin
            merge = W2'(i_item.start_ms) <= open_end_gap;
            if (i_cfg.unordered && (i_item.start_ms < i_state.open_start)) begin
                merge = 1'b0;
            end
        end

        new_start = (i_item.start_ms < i_state.open_start) ? i_item.start_ms
                                                           : i_state.open_start;
        desc_len  = open_end - {1'b0, new_start};
        asc_len   = rec_end - {1'b0, i_state.open_start};

        limit_reached = !i_cfg.unordered && (i_cfg.period_limit != '0)
                     && (i_state.period_count >= i_cfg.period_limit);
        count_inc = (i_state.period_count < tpc_pkg::COUNT_MAX)
                  ? i_state.period_count + 1'b1 : i_state.period_count;

        o_state  = i_state;
        o_emit   = 1'b0;
        o_result.period_start  = i_state.open_start;
        o_result.period_length = i_state.open_length;
        o_result.from_flush    = 1'b0;
        o_result.limit_hit     = 1'b0;

        if (i_item.req_type == tpc_pkg::REQ_FLUSH) begin
            o_emit              = i_state.open_valid;
            o_result.from_flush = 1'b1;
            o_state.open_valid   = 1'b0;
            o_state.period_count = '0;
            o_state.stopped      = 1'b0;
        end else if (!i_state.stopped && in_window) begin
            if (!i_state.open_valid) begin
                o_state.open_start   = i_item.start_ms;
                o_state.open_length  = tpc_pkg::TIME_W'(i_item.duration_ms);
                o_state.open_valid   = 1'b1;
                o_state.period_count = count_inc;
            end else if (merge) begin
                if (i_cfg.descending) begin
                    o_state.open_start  = new_start;
                    o_state.open_length = desc_len[tpc_pkg::TIME_W]
                                        ? tpc_pkg::TIME_MAX
                                        : desc_len[tpc_pkg::TIME_W-1:0];
                end else if (rec_end > open_end) begin
                    o_state.open_length = asc_len[tpc_pkg::TIME_W]
                                        ? tpc_pkg::TIME_MAX
                                        : asc_len[tpc_pkg::TIME_W-1:0];
                end
            end else if (limit_reached) begin
                o_emit             = 1'b1;
                o_result.limit_hit = 1'b1;
                o_state.open_valid = 1'b0;
                o_state.stopped    = 1'b1;
            end else begin
                o_emit               = 1'b1;
                o_state.open_start   = i_item.start_ms;
                o_state.open_length  = tpc_pkg::TIME_W'(i_item.duration_ms);
                o_state.period_count = count_inc;
            end
        end
    end

endmodule
